FILE: design/mac_pkg.sv
`default_nettype none

package mac_pkg;

    // Ring depth, also the largest usable window
    localparam int MAX_WINDOW = 256;

    localparam int PRICE_W = 32;
    localparam int CFG_W   = 9;
    localparam int PTR_W   = $clog2(MAX_WINDOW);
    localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = PRICE_W + $clog2(MAX_WINDOW);
    localparam int STEP_W  = $clog2(SUM_W + 1);
    localparam int ADDR_W  = 3;
    localparam int APB_W   = 32;
    localparam int OUT_W   = 72;
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam logic [CFG_W-1:0] SHORT_RESET = 9'd5;
    localparam logic [CFG_W-1:0] LONG_RESET  = 9'd20;

    // Register indexes (paddr[2])
    localparam logic REG_SHORT = 1'b0;
    localparam logic REG_LONG  = 1'b1;

    typedef enum logic [1:0] {
        REL_NONE  = 2'd0,
        REL_ABOVE = 2'd1,
        REL_BELOW = 2'd2,
        REL_EQUAL = 2'd3
    } t_rel;

    typedef enum logic [1:0] {
        SIG_HOLD = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } t_sig;

    // One word handed from the front to the back
    typedef struct packed {
        logic [SUM_W-1:0] short_sum;
        logic [SUM_W-1:0] long_sum;
        logic [WIN_W-1:0] short_win;
        logic [WIN_W-1:0] long_win;
        logic             short_ready;
        logic             long_ready;
    } t_job;

    // Zero acts as one, anything above the ring depth acts as the depth
    function automatic logic [WIN_W-1:0] clamp_window(input logic [CFG_W-1:0] w);
        logic [WIN_W-1:0] r;
        if (w == '0) begin
            r = WIN_W'(1);
        end else if (32'(w) > MAX_WINDOW) begin
            r = WIN_W'(MAX_WINDOW);
        end else begin
            r = WIN_W'(w);
        end
        return r;
    endfunction

    // Slot written w words before the slot at wp
    function automatic logic [PTR_W-1:0] slot_back(input logic [PTR_W-1:0] wp,
                                                   input logic [WIN_W-1:0] w);
        logic [WIN_W:0] p;
        p = (WIN_W+1)'(wp) + (WIN_W+1)'(MAX_WINDOW) - (WIN_W+1)'(w);
        if (p >= (WIN_W+1)'(MAX_WINDOW)) begin
            p = p - (WIN_W+1)'(MAX_WINDOW);
        end
        return PTR_W'(p);
    endfunction

endpackage

`default_nettype wire

FILE: design/mac_front.sv
`default_nettype none

module mac_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_restart,
    input  wire logic [mac_pkg::WIN_W-1:0]   i_short_win,
    input  wire logic [mac_pkg::WIN_W-1:0]   i_long_win,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [mac_pkg::PRICE_W-1:0] i_price,
    input  wire logic                    i_full,
    output logic                         o_push,
    output mac_pkg::t_job                o_job
);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_SUM  = 2'b10
    } t_fstate;

    t_fstate r_state, n_state;

    logic [mac_pkg::PRICE_W-1:0] r_ring [mac_pkg::MAX_WINDOW];
    logic [mac_pkg::PRICE_W-1:0] r_rd_short, r_rd_long, r_price;
    logic                        r_need_short, r_need_long;
    logic [mac_pkg::PTR_W-1:0]   r_wp, n_wp;
    logic [mac_pkg::WIN_W-1:0]   r_cnt, n_cnt;
    logic [mac_pkg::SUM_W-1:0]   r_sum_short, n_sum_short;
    logic [mac_pkg::SUM_W-1:0]   r_sum_long, n_sum_long;
    logic                        accept;

    assign o_ready = (r_state == F_IDLE);
    assign accept  = i_valid && o_ready;
    assign o_push  = (r_state == F_SUM) && !i_full;

    // Ring: write the new price, read the two leaving prices (old data on a shared slot)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_wp] <= i_price;
            r_rd_short   <= r_ring[mac_pkg::slot_back(r_wp, i_short_win)];
            r_rd_long    <= r_ring[mac_pkg::slot_back(r_wp, i_long_win)];
            r_price      <= i_price;
            r_need_short <= (r_cnt >= i_short_win);
            r_need_long  <= (r_cnt >= i_long_win);
        end
    end

    // Sum update and next pointer/count
    always_comb begin
        n_sum_short = r_sum_short
                    - (r_need_short ? mac_pkg::SUM_W'(r_rd_short) : '0)
                    + mac_pkg::SUM_W'(r_price);
        n_sum_long  = r_sum_long
                    - (r_need_long ? mac_pkg::SUM_W'(r_rd_long) : '0)
                    + mac_pkg::SUM_W'(r_price);
        n_cnt = (r_cnt == mac_pkg::WIN_W'(mac_pkg::MAX_WINDOW)) ? r_cnt : r_cnt + 1'b1;
        n_wp  = (r_wp == mac_pkg::PTR_W'(mac_pkg::MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;
    end

    always_comb begin
        o_job.short_sum   = n_sum_short;
        o_job.long_sum    = n_sum_long;
        o_job.short_win   = i_short_win;
        o_job.long_win    = i_long_win;
        o_job.short_ready = (n_cnt >= i_short_win);
        o_job.long_ready  = (n_cnt >= i_long_win);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (accept) n_state = F_SUM;
            F_SUM:   if (o_push) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_wp        <= '0;
            r_cnt       <= '0;
            r_sum_short <= '0;
            r_sum_long  <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_wp <= n_wp;
            end
            if (i_restart) begin
                r_cnt       <= '0;
                r_sum_short <= '0;
                r_sum_long  <= '0;
            end else if (o_push) begin
                r_cnt       <= n_cnt;
                r_sum_short <= n_sum_short;
                r_sum_long  <= n_sum_long;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/mac_queue.sv
`default_nettype none

module mac_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire mac_pkg::t_job i_job,
    output logic         o_full,
    input  wire logic    i_pop,
    output mac_pkg::t_job o_job,
    output logic         o_empty
);

    mac_pkg::t_job               r_mem [mac_pkg::Q_DEPTH];
    logic [mac_pkg::QPTR_W-1:0]  r_wr, r_rd;
    logic [mac_pkg::QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == mac_pkg::QCNT_W'(mac_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers wrap at the depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == mac_pkg::QPTR_W'(mac_pkg::Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == mac_pkg::QPTR_W'(mac_pkg::Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/mac_back.sv
`default_nettype none

module mac_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_restart,
    input  wire logic                  i_empty,
    input  wire mac_pkg::t_job         i_job,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [mac_pkg::OUT_W-1:0]  o_data
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_OUT  = 3'b100
    } t_bstate;

    localparam int DW = mac_pkg::WIN_W + mac_pkg::SUM_W;

    // One restoring step: bring in the dividend MSB, subtract if it fits
    function automatic logic [DW-1:0] div_step(input logic [mac_pkg::WIN_W-1:0] rem,
                                               input logic [mac_pkg::SUM_W-1:0] dvd,
                                               input logic [mac_pkg::WIN_W-1:0] dsr);
        logic [mac_pkg::WIN_W:0] t;
        logic                    q;
        t = {rem, dvd[mac_pkg::SUM_W-1]};
        q = (t >= {1'b0, dsr});
        if (q) begin
            t = t - {1'b0, dsr};
        end
        return {t[mac_pkg::WIN_W-1:0], dvd[mac_pkg::SUM_W-2:0], q};
    endfunction

    t_bstate r_state, n_state;

    logic [mac_pkg::STEP_W-1:0]  r_step;
    logic [mac_pkg::WIN_W-1:0]   r_rem_s, r_rem_l, r_div_s, r_div_l;
    logic [mac_pkg::SUM_W-1:0]   r_dvd_s, r_dvd_l;
    logic                        r_sr, r_lr;
    mac_pkg::t_rel               r_prev, n_rel;
    mac_pkg::t_sig               n_sig;
    logic [DW-1:0]               step_s, step_l;
    logic [mac_pkg::PRICE_W-1:0] s_avg, l_avg;
    logic                        r_valid;
    logic [mac_pkg::OUT_W-1:0]   r_data;
    logic                        emit;

    assign step_s = div_step(r_rem_s, r_dvd_s, r_div_s);
    assign step_l = div_step(r_rem_l, r_dvd_l, r_div_l);
    assign s_avg  = r_dvd_s[mac_pkg::PRICE_W-1:0];
    assign l_avg  = r_dvd_l[mac_pkg::PRICE_W-1:0];

    assign o_pop   = (r_state == B_IDLE) && !i_empty;
    assign emit    = (r_state == B_OUT) && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Relation of the averages and crossover decision
    always_comb begin
        n_rel = mac_pkg::REL_NONE;
        n_sig = mac_pkg::SIG_HOLD;
        if (r_sr && r_lr) begin
            if (s_avg > l_avg) begin
                n_rel = mac_pkg::REL_ABOVE;
            end else if (s_avg < l_avg) begin
                n_rel = mac_pkg::REL_BELOW;
            end else begin
                n_rel = mac_pkg::REL_EQUAL;
            end
            if (n_rel == mac_pkg::REL_ABOVE && r_prev == mac_pkg::REL_BELOW) begin
                n_sig = mac_pkg::SIG_BUY;
            end else if (n_rel == mac_pkg::REL_BELOW && r_prev == mac_pkg::REL_ABOVE) begin
                n_sig = mac_pkg::SIG_SELL;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (o_pop) n_state = B_DIV;
            B_DIV:   if (r_step == mac_pkg::STEP_W'(1)) n_state = B_OUT;
            B_OUT:   if (emit) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // Divider lanes
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem_s <= '0;
            r_rem_l <= '0;
            r_dvd_s <= i_job.short_sum;
            r_dvd_l <= i_job.long_sum;
            r_div_s <= i_job.short_win;
            r_div_l <= i_job.long_win;
            r_sr    <= i_job.short_ready;
            r_lr    <= i_job.long_ready;
            r_step  <= mac_pkg::STEP_W'(mac_pkg::SUM_W);
        end else if (r_state == B_DIV) begin
            r_rem_s <= step_s[DW-1 -: mac_pkg::WIN_W];
            r_dvd_s <= step_s[mac_pkg::SUM_W-1:0];
            r_rem_l <= step_l[DW-1 -: mac_pkg::WIN_W];
            r_dvd_l <= step_l[mac_pkg::SUM_W-1:0];
            r_step  <= r_step - 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_data <= {4'b0000, n_sig, r_lr, r_sr, l_avg, s_avg};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_prev  <= mac_pkg::REL_NONE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_restart) begin
                r_prev <= mac_pkg::REL_NONE;
            end else if (emit) begin
                r_prev <= n_rel;
            end
            if (emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/moving_average_crossover_top.sv
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tdata[31:0] price (Q24.8)
// m_axis    out  m_axis_tvalid/tready      tdata: short_avg, long_avg, short_ready,
//                                          long_ready, signal
// apb       in   psel/penable/pwrite       0x0 short_window, 0x4 long_window
//
// Front handles one word at a time: ring access, then sum update (held while
// the queue is full). The back runs each word through the bit-serial divider
// for SUM_W (40) quotient bits between a load and an output step, one word at a time.
// A 2-deep queue between front and back lets either side stall independently.
// Reset is synchronous; the price ring needs no clearing pass (slots are read
// only after being written). Any register write restarts averaging.
`default_nettype none

module moving_average_crossover_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [mac_pkg::PRICE_W-1:0]  s_axis_tdata,  // [31:0] price
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [31:0] short_avg, [63:32] long_avg, [64] short_ready, [65] long_ready,
    // [67:66] signal, [71:68] zero
    output logic [mac_pkg::OUT_W-1:0]         m_axis_tdata,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mac_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [mac_pkg::APB_W-1:0]    pwdata,
    output logic [mac_pkg::APB_W-1:0]         prdata,
    output logic                              pready
);

    logic [mac_pkg::CFG_W-1:0] r_short_window, r_long_window;
    logic                      cfg_wr;
    logic                      q_full, q_empty, q_push, q_pop;
    mac_pkg::t_job             push_job, pop_job;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == mac_pkg::REG_LONG)
                  ? mac_pkg::APB_W'(r_long_window)
                  : mac_pkg::APB_W'(r_short_window);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_window <= mac_pkg::SHORT_RESET;
            r_long_window  <= mac_pkg::LONG_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == mac_pkg::REG_SHORT) begin
                r_short_window <= pwdata[mac_pkg::CFG_W-1:0];
            end else begin
                r_long_window <= pwdata[mac_pkg::CFG_W-1:0];
            end
        end
    end

    mac_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (cfg_wr),
        .i_short_win (mac_pkg::clamp_window(r_short_window)),
        .i_long_win  (mac_pkg::clamp_window(r_long_window)),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_price     (s_axis_tdata),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    mac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (pop_job),
        .o_empty (q_empty)
    );

    mac_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_wr),
        .i_empty   (q_empty),
        .i_job     (pop_job),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: design/mac_checker.sv
`default_nettype none

module mac_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata
);

    // Stalled word stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    // Signal code is only hold, buy or sell
    a_sig_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[67:66] == mac_pkg::SIG_HOLD)
                        || (m_axis_tdata[67:66] == mac_pkg::SIG_BUY)
                        || (m_axis_tdata[67:66] == mac_pkg::SIG_SELL)))
        else $error("illegal signal code");

    // A crossover needs both windows filled
    a_sig_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[67:66] != mac_pkg::SIG_HOLD)
            |-> m_axis_tdata[64] && m_axis_tdata[65])
        else $error("crossover reported before both windows filled");

    // Pad bits above the signal stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[71:68] == 4'd0))
        else $error("pad bits not zero");

endmodule

bind moving_average_crossover_top mac_checker u_mac_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
